FILE: hw/rtl/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the packed list with insert and delete.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int VALUE_W    = 31;
  localparam int POS_W      = 8;
  localparam int COUNT_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int CAPACITY_D = 128;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } plc_action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } plc_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FOLD,
    S_OUT
  } plc_state_t;

  typedef struct packed {
    logic               action;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } plc_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  removed_value;
    logic [COUNT_W-1:0]  count_after;
    logic [STATUS_W-1:0] status;
  } plc_out_t;

  typedef struct packed {
    logic               en;
    logic               action;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
  } plc_ctl_t;

endpackage

FILE: hw/rtl/plc_cell.sv
// ----------------------------------------------------------------------------
// plc_cell
// One list slot: takes its left or right neighbour, or the new value.
// ----------------------------------------------------------------------------
module plc_cell import plc_pkg::*; #(
  parameter int          CW  = 8,
  parameter int unsigned IDX = 0
) (
  input  logic               clk,
  input  plc_ctl_t           ctl_i,
  input  logic [VALUE_W-1:0] left_i,
  input  logic [VALUE_W-1:0] right_i,
  output logic [VALUE_W-1:0] value_o,
  output logic [VALUE_W-1:0] hit_o
);

  logic [VALUE_W-1:0] ent_r;
  logic [VALUE_W-1:0] ent_nxt;
  logic [CW-1:0]      pos_w;
  logic [CW-1:0]      idx_w;

  assign pos_w = CW'(ctl_i.pos);
  assign idx_w = CW'(IDX);

  always_comb begin
    ent_nxt = ent_r;
    if (ctl_i.en) begin
      if (ctl_i.action == ACT_INSERT) begin
        if (idx_w > pos_w) begin
          ent_nxt = left_i;
        end else if (idx_w == pos_w) begin
          ent_nxt = ctl_i.value;
        end
      end else begin
        if (idx_w >= pos_w) begin
          ent_nxt = right_i;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign value_o = ent_r;
  assign hit_o   = (idx_w == pos_w) ? ent_r : '0;

endmodule

FILE: hw/rtl/plc_fold.sv
// ----------------------------------------------------------------------------
// plc_fold
// OR-fold of the slot taps, halving the row once per cycle while step_i is high.
// ----------------------------------------------------------------------------
module plc_fold import plc_pkg::*; #(
  parameter int N = CAPACITY_D
) (
  input  logic               clk,
  input  logic               load_i,
  input  logic               step_i,
  input  logic [VALUE_W-1:0] leaf_i [N],
  output logic [VALUE_W-1:0] sum_o
);

  logic [VALUE_W-1:0] red_r   [N];
  logic [VALUE_W-1:0] red_nxt [N];

  for (genvar i = 0; i < N; i++) begin : g_node
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    if (2 * i < N) begin : g_lo
      assign lo = red_r[2*i];
    end else begin : g_lo0
      assign lo = '0;
    end
    if (2 * i + 1 < N) begin : g_hi
      assign hi = red_r[2*i+1];
    end else begin : g_hi0
      assign hi = '0;
    end
    always_comb begin
      red_nxt[i] = red_r[i];
      if (load_i) begin
        red_nxt[i] = leaf_i[i];
      end else if (step_i) begin
        red_nxt[i] = lo | hi;
      end
    end
    always_ff @(posedge clk) begin
      red_r[i] <= red_nxt[i];
    end
  end

  assign sum_o = red_r[0];

endmodule

FILE: hw/rtl/packed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// packed_list_insert_delete
// Left-packed list of up to CAPACITY_ENTRIES values with insert and delete.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Each slot is a cell that shifts toward or away
// from its neighbour in the accept cycle, so the list itself updates at the
// accept edge. The value removed by a delete is gathered by an OR-fold that
// halves the row each cycle while the state machine is in S_FOLD; the result
// beat is raised in S_OUT once the fold is done. One item is in flight at a
// time: input ready returns in the cycle after the result beat is taken, and
// the receiver can hold off the result beat.
// Inserts into a full list and out-of-range indices leave the list untouched
// and report a status code. Input ready stays low during reset.
// ----------------------------------------------------------------------------
module packed_list_insert_delete import plc_pkg::*; #(
  parameter int CAPACITY_ENTRIES = CAPACITY_D
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  plc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output plc_out_t out_data
);

  localparam int LEN_W = $clog2(CAPACITY_ENTRIES + 1);
  localparam int CW    = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int LVL   = $clog2(CAPACITY_ENTRIES);
  localparam int CNT_W = $clog2(LVL + 1);

  plc_state_t          state_r;
  plc_state_t          state_nxt;
  logic [LEN_W-1:0]    len_r;
  logic [LEN_W-1:0]    len_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic                del_ok_r;
  logic [STATUS_W-1:0] status_r;
  logic [COUNT_W-1:0]  count_r;

  logic                accept;
  logic                ok;
  logic [STATUS_W-1:0] status_c;
  logic [LEN_W-1:0]    len_op;
  logic [CW-1:0]       len_ext;
  logic [CW-1:0]       pos_ext;
  plc_ctl_t            ctl;
  logic [VALUE_W-1:0]  removed;

  logic [VALUE_W-1:0]  cell_val [CAPACITY_ENTRIES];
  logic [VALUE_W-1:0]  cell_hit [CAPACITY_ENTRIES];

  assign accept  = in_valid && in_ready;
  assign len_ext = CW'(len_r);
  assign pos_ext = CW'(in_data.position);

  always_comb begin
    status_c = STAT_DONE;
    len_op   = len_r;
    if (in_data.action == ACT_INSERT) begin
      if (len_r == LEN_W'(CAPACITY_ENTRIES)) begin
        status_c = STAT_FULL;
      end else if (pos_ext > len_ext) begin
        status_c = STAT_RANGE;
      end else begin
        len_op = len_r + LEN_W'(1);
      end
    end else begin
      if (pos_ext >= len_ext) begin
        status_c = STAT_RANGE;
      end else begin
        len_op = len_r - LEN_W'(1);
      end
    end
  end

  assign ok = (status_c == STAT_DONE);

  assign ctl.en     = accept && ok;
  assign ctl.action = in_data.action;
  assign ctl.value  = in_data.value;
  assign ctl.pos    = in_data.position;

  for (genvar i = 0; i < CAPACITY_ENTRIES; i++) begin : g_cell
    logic [VALUE_W-1:0] left_w;
    logic [VALUE_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_val[i-1];
    end
    if (i == CAPACITY_ENTRIES - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_val[i+1];
    end
    plc_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .value_o (cell_val[i]),
      .hit_o   (cell_hit[i])
    );
  end

  plc_fold #(
    .N (CAPACITY_ENTRIES)
  ) u_fold (
    .clk    (clk),
    .load_i (accept),
    .step_i (state_r == S_FOLD),
    .leaf_i (cell_hit),
    .sum_o  (removed)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_FOLD;
          cnt_nxt   = '0;
          len_nxt   = len_op;
        end
      end
      S_FOLD: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(LVL - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      del_ok_r <= ok && (in_data.action == ACT_DELETE);
      status_r <= status_c;
      count_r  <= COUNT_W'(len_op);
    end
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready  = rst_n;
      S_FOLD:  in_ready  = 1'b0;
      S_OUT:   out_valid = 1'b1;
      default: in_ready  = 1'b0;
    endcase
  end

  assign out_data.removed_value = del_ok_r ? removed : '0;
  assign out_data.count_after   = count_r;
  assign out_data.status        = status_r;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packed list with insert and delete.
// ----------------------------------------------------------------------------
// Drives insert and delete beats through the valid/ready input channel. A
// scoreboard keeps its own copy of the list and its length and works out the
// expected result of every accepted beat. Each result beat is compared field
// by field with the oldest expectation. A short directed opening covers the
// empty, first, last, middle and out-of-range cases. Random phases then grow
// the list to full, drain it to empty and mix both, with random gaps on
// either side, one long receiver hold-off and one full drain pause.
// ----------------------------------------------------------------------------
module tb_top import plc_pkg::*; ();

  localparam int RANDOM_BEATS = 1950;
  localparam int CALM_FROM    = 1750;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int TAIL_CYCLES  = 20;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  class list_scoreboard;
    logic [VALUE_W-1:0] store [CAPACITY_D];
    int                 fill;
    int                 peak;
    plc_out_t           pending_outcomes [$];
    int                 errors;
    int                 n_insert, n_delete, n_full, n_range, n_checked;

    function new();
      fill = 0;
      peak = 0;
      errors = 0;
      n_insert = 0;
      n_delete = 0;
      n_full = 0;
      n_range = 0;
      n_checked = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function plc_out_t list_op_outcome(plc_in_t beat);
      plc_out_t res;
      res.removed_value = '0;
      res.status        = STAT_DONE;
      if (beat.action == ACT_INSERT) begin
        if (fill >= CAPACITY_D) begin
          res.status = STAT_FULL;
          n_full++;
        end else if (int'(beat.position) > fill) begin
          res.status = STAT_RANGE;
          n_range++;
        end else begin
          for (int i = fill; i > int'(beat.position); i--) store[i] = store[i-1];
          store[beat.position] = beat.value;
          fill++;
          n_insert++;
        end
      end else begin
        if (int'(beat.position) >= fill) begin
          res.status = STAT_RANGE;
          n_range++;
        end else begin
          res.removed_value = store[beat.position];
          for (int i = int'(beat.position); i + 1 < fill; i++) store[i] = store[i+1];
          fill--;
          n_delete++;
        end
      end
      if (fill > peak) peak = fill;
      res.count_after = COUNT_W'(fill);
      return res;
    endfunction

    function void note_input(plc_in_t beat);
      pending_outcomes.push_back(list_op_outcome(beat));
    endfunction

    task check_result(plc_out_t got);
      plc_out_t want;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result beat with nothing expected");
        return;
      end
      want = pending_outcomes.pop_front();
      n_checked++;
      if (got.removed_value !== want.removed_value)
        report_mismatch($sformatf("removed_value got %h want %h",
                                  got.removed_value, want.removed_value));
      if (got.count_after !== want.count_after)
        report_mismatch($sformatf("count_after got %0d want %0d",
                                  got.count_after, want.count_after));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  plc_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  plc_out_t out_data;

  list_scoreboard sb = new();
  logic           calm = 1'b0;
  logic           hold_req = 1'b0;
  int             idle_cycles = 0;

  packed_list_insert_delete DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_input(in_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a beat", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic plc_in_t beat_of(plc_action_t act, logic [VALUE_W-1:0] v,
                                      logic [POS_W-1:0] p);
    plc_in_t b;
    b.action   = act;
    b.value    = v;
    b.position = p;
    return b;
  endfunction

  // hold the beat until taken, then advance to the next falling edge
  task automatic send_beat(plc_in_t b);
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic sender_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // phase 0 grows, 2 drains, 1 and 3 are balanced
  function automatic plc_in_t random_beat(int phase);
    plc_in_t          b;
    int               ins_pct;
    int               r;
    int               len;
    logic [VALUE_W-1:0] v;
    logic [POS_W-1:0] p;
    len = sb.fill;
    case (phase)
      0: ins_pct = 90;
      2: ins_pct = 10;
      default: ins_pct = 50;
    endcase
    r = $urandom_range(0, 15);
    if (r == 0) v = '0;
    else if (r == 1) v = VALUE_MAX;
    else v = VALUE_W'($urandom);
    b.action = ($urandom_range(1, 100) <= ins_pct) ? ACT_INSERT : ACT_DELETE;
    b.value  = v;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      p = POS_W'($urandom_range(0, 255));
    end else if (r == 1) begin
      p = '0;
    end else if (b.action == ACT_INSERT) begin
      p = (r == 2) ? POS_W'(len) : POS_W'($urandom_range(0, len));
    end else begin
      if (len == 0) p = '0;
      else p = (r == 2) ? POS_W'(len - 1) : POS_W'($urandom_range(0, len - 1));
    end
    b.position = p;
    return b;
  endfunction

  initial begin : receiver
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : sender
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_beat(beat_of(ACT_DELETE, '0, 8'd0));
    send_beat(beat_of(ACT_DELETE, VALUE_MAX, 8'd255));
    send_beat(beat_of(ACT_INSERT, 31'd1, 8'd1));
    send_beat(beat_of(ACT_INSERT, '0, 8'd0));
    send_beat(beat_of(ACT_INSERT, VALUE_MAX, 8'd1));
    send_beat(beat_of(ACT_INSERT, 31'h2AAA_AAAA, 8'd0));
    send_beat(beat_of(ACT_INSERT, 31'h5555_5555, 8'd1));
    send_beat(beat_of(ACT_INSERT, 31'd7, 8'd4));
    send_beat(beat_of(ACT_INSERT, 31'd9, 8'd6));
    send_beat(beat_of(ACT_INSERT, 31'd9, 8'd255));
    send_beat(beat_of(ACT_INSERT, 31'd9, 8'd128));
    send_beat(beat_of(ACT_DELETE, '0, 8'd5));
    send_beat(beat_of(ACT_DELETE, VALUE_MAX, 8'd255));
    send_beat(beat_of(ACT_DELETE, '0, 8'd2));
    send_beat(beat_of(ACT_DELETE, '0, 8'd3));
    send_beat(beat_of(ACT_DELETE, '0, 8'd0));
    send_beat(beat_of(ACT_INSERT, 31'h1234, 8'd2));
    send_beat(beat_of(ACT_DELETE, '0, 8'd1));

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == CALM_FROM) calm = 1'b1;
      if (i == 400) hold_req = 1'b1;
      if (i == 900) begin
        in_valid <= 1'b0;
        while (sb.pending_outcomes.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      send_beat(random_beat((i / 250) % 4));
      if (!calm && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 16));
    end
    in_valid <= 1'b0;

    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_outcomes.size() != 0) sb.report_mismatch("expected results left over");

    $display("checked %0d results: %0d inserts, %0d deletes, %0d refused as full,",
             sb.n_checked, sb.n_insert, sb.n_delete, sb.n_full);
    $display("%0d out of range; list length peaked at %0d entries",
             sb.n_range, sb.peak);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
